>>> hdl/assert_macros.svh
// assertion macros used by the top level of the coincidence counter
// no dependencies; clock and reset port names are fixed by the house style
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_SYNC(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hdl/tcc_pkg.sv
// types and constants of the two-channel coincidence counter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

   localparam int unsigned TIME_IN_WIDTH = 32;
   localparam int unsigned WINDOW_WIDTH  = 16;
   localparam int unsigned COUNT_OUT_WIDTH = 16;
   localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = 16'd50;

   typedef enum logic {
      REQ_PULSE = 1'b0,
      REQ_READ  = 1'b1
   } req_kind_type;

   typedef struct packed {
      req_kind_type               req_type;
      logic                       channel;
      logic [TIME_IN_WIDTH-1:0]   time_us;
   } req_word_type;

   typedef struct packed {
      logic [COUNT_OUT_WIDTH-1:0] single_first;
      logic [COUNT_OUT_WIDTH-1:0] single_second;
      logic [COUNT_OUT_WIDTH-1:0] coincidences;
   } rsp_word_type;

   // control handed from the input stage to the counting engine
   typedef struct packed {
      logic         fire;
      req_kind_type kind;
      logic         channel;
   } step_ctl_type;

endpackage

`default_nettype wire

>>> hdl/tcc_engine.sv
// counting engine: last pulse times, window compare and the three counters
// depends on tcc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcc_engine import tcc_pkg::*; #(
   parameter int unsigned COUNT_WIDTH = 16,
   parameter int unsigned TIME_WIDTH  = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire step_ctl_type              step,
   input  wire logic [TIME_IN_WIDTH-1:0]  time_us,
   input  wire logic [WINDOW_WIDTH-1:0]   window,
   output rsp_word_type                   counts_now
);

   logic [TIME_WIDTH-1:0]  last_first_ff, last_first_in;
   logic [TIME_WIDTH-1:0]  last_second_ff, last_second_in;
   logic [COUNT_WIDTH-1:0] cnt_first_ff, cnt_first_in;
   logic [COUNT_WIDTH-1:0] cnt_second_ff, cnt_second_in;
   logic [COUNT_WIDTH-1:0] cnt_coinc_ff, cnt_coinc_in;

   logic [TIME_WIDTH+TIME_IN_WIDTH-1:0] time_wide;
   logic [TIME_WIDTH+WINDOW_WIDTH-1:0]  window_wide;
   logic [TIME_WIDTH-1:0]               t_now;
   logic [TIME_WIDTH-1:0]               win_ext;
   logic [TIME_WIDTH-1:0]               other_time;
   logic [TIME_WIDTH-1:0]               elapsed;
   logic                                hit;

   logic [COUNT_WIDTH+COUNT_OUT_WIDTH-1:0] first_wide, second_wide, coinc_wide;

   // timestamp and window fitted to the time width
   assign time_wide   = {{TIME_WIDTH{1'b0}}, time_us};
   assign window_wide = {{TIME_WIDTH{1'b0}}, window};
   assign t_now       = time_wide[TIME_WIDTH-1:0];
   assign win_ext     = window_wide[TIME_WIDTH-1:0];

   assign other_time = step.channel ? last_first_ff : last_second_ff;
   assign elapsed    = t_now - other_time;
   assign hit        = (elapsed < win_ext);

   always_comb begin
      last_first_in  = last_first_ff;
      last_second_in = last_second_ff;
      cnt_first_in   = cnt_first_ff;
      cnt_second_in  = cnt_second_ff;
      cnt_coinc_in   = cnt_coinc_ff;
      if (step.fire) begin
         if (step.kind == REQ_READ) begin
            cnt_first_in  = '0;
            cnt_second_in = '0;
            cnt_coinc_in  = '0;
         end else begin
            if (step.channel) begin
               last_second_in = t_now;
            end else begin
               last_first_in = t_now;
            end
            if (hit) begin
               // the other channel's earlier single becomes half of this pair
               cnt_coinc_in = cnt_coinc_ff + 1'b1;
               if (step.channel) begin
                  cnt_first_in = cnt_first_ff - 1'b1;
               end else begin
                  cnt_second_in = cnt_second_ff - 1'b1;
               end
            end else if (step.channel) begin
               cnt_second_in = cnt_second_ff + 1'b1;
            end else begin
               cnt_first_in = cnt_first_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_first_ff  <= '0;
         last_second_ff <= '0;
         cnt_first_ff   <= '0;
         cnt_second_ff  <= '0;
         cnt_coinc_ff   <= '0;
      end else begin
         last_first_ff  <= last_first_in;
         last_second_ff <= last_second_in;
         cnt_first_ff   <= cnt_first_in;
         cnt_second_ff  <= cnt_second_in;
         cnt_coinc_ff   <= cnt_coinc_in;
      end
   end

   // low bits of each count on the result word
   assign first_wide  = {{COUNT_OUT_WIDTH{1'b0}}, cnt_first_ff};
   assign second_wide = {{COUNT_OUT_WIDTH{1'b0}}, cnt_second_ff};
   assign coinc_wide  = {{COUNT_OUT_WIDTH{1'b0}}, cnt_coinc_ff};

   assign counts_now.single_first  = first_wide[COUNT_OUT_WIDTH-1:0];
   assign counts_now.single_second = second_wide[COUNT_OUT_WIDTH-1:0];
   assign counts_now.coincidences  = coinc_wide[COUNT_OUT_WIDTH-1:0];

endmodule

`default_nettype wire

>>> hdl/two_channel_coincidence_counter.sv
// flow: a read word is accepted into the input register, processed when it leaves it, and
//   its counts show on rsp_word from the response register; pulse words give no response
// throughput: one word per cycle, set by the subtract-compare and counter update, except that
//   a read waits in the input register while rsp_stall holds a full response register
// reset (synchronous): counts and last pulse times go to zero, the window to 50, both
//   registers empty; top level of the coincidence counter; depends on tcc_pkg, tcc_engine, assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module two_channel_coincidence_counter import tcc_pkg::*; #(
   parameter int unsigned COUNT_WIDTH = 16,
   parameter int unsigned TIME_WIDTH  = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire req_word_type             req_word,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output rsp_word_type                  rsp_word,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [WINDOW_WIDTH-1:0]  csr_data
);

   logic                    s1_valid_ff, s1_valid_in;
   req_word_type            s1_word_ff, s1_word_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_word_type            rsp_word_ff, rsp_word_in;
   logic [WINDOW_WIDTH-1:0] window_ff, window_in;

   logic         out_free;
   logic         advance;
   logic         accept;
   logic         fire_read;
   step_ctl_type step;
   rsp_word_type counts_now;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // only a read needs room in the response register
   assign advance   = !s1_valid_ff || (s1_word_ff.req_type == REQ_PULSE) || out_free;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   assign step.fire    = s1_valid_ff && advance;
   assign step.kind    = s1_word_ff.req_type;
   assign step.channel = s1_word_ff.channel;
   assign fire_read    = step.fire && (s1_word_ff.req_type == REQ_READ);

   assign csr_ready = 1'b1;
   assign window_in = (csr_valid && csr_ready) ? csr_data : window_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_word_in  = s1_word_ff;
      if (advance) begin
         s1_valid_in = req_valid;
      end
      if (accept) begin
         s1_word_in = req_word;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (fire_read) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = counts_now;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= WINDOW_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         window_ff    <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff  <= s1_word_in;
      rsp_word_ff <= rsp_word_in;
   end

   tcc_engine #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .time_us    (s1_word_ff.time_us),
      .window     (window_ff),
      .counts_now (counts_now)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `ASSERT_SYNC(a_read_waits_for_room, (s1_valid_ff && s1_word_ff.req_type == REQ_READ && rsp_valid_ff && rsp_stall) |-> !step.fire, "read fired into a full response register")
   `ASSERT_SYNC(a_read_gives_word, fire_read |=> rsp_valid, "read did not produce a response word")
   `ASSERT_SYNC(a_read_clears, fire_read |=> (counts_now == '0), "counters not cleared after read")
   `ASSERT_ALWAYS(a_reset_empties, reset |=> (!rsp_valid && !s1_valid_ff), "registers not empty after reset")

endmodule

`default_nettype wire

>>> test/tb_two_channel_coincidence_counter.sv
// testbench of the two-channel coincidence counter: directed pulse pairs, window extremes and
// random pulse trains, checked against an in-bench count predictor; depends on tcc_pkg and the top
`timescale 1ns / 1ps

module tb_two_channel_coincidence_counter;
   import tcc_pkg::*;

   localparam int unsigned FIRST_SINGLES  = 0;
   localparam int unsigned SECOND_SINGLES = 1;
   localparam int unsigned COINCIDENT     = 2;
   localparam logic CH_FIRST  = 1'b0;
   localparam logic CH_SECOND = 1'b1;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned DRAIN_LIMIT  = 20000;
   localparam int unsigned MAX_REPORTS  = 10;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_word_type            req_word = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_word_type            rsp_word;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [WINDOW_WIDTH-1:0] csr_data = '0;

   // predictor state
   logic [WINDOW_WIDTH-1:0]    window_now;
   logic [TIME_IN_WIDTH-1:0]   last_pulse_us [2];
   logic [COUNT_OUT_WIDTH-1:0] tally [3];
   rsp_word_type               pending_counts [$];

   int unsigned mismatches = 0;
   bit          sender_idles = 1'b0;
   bit          receiver_stalls = 1'b0;
   int unsigned burst_left = 0;
   bit          stall_phase = 1'b0;
   int unsigned stall_left = 0;
   logic [31:0] now_us = '0;

   always #5 clock = ~clock;

   two_channel_coincidence_counter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   function automatic void clear_tally();
      for (int i = 0; i < 3; i++) tally[i] = '0;
   endfunction

   // advance the count predictor by one accepted word
   function automatic void count_word(req_word_type w);
      logic [TIME_IN_WIDTH-1:0] since_other;
      rsp_word_type             counts;
      logic                     other;
      if (w.req_type == REQ_READ) begin
         counts.single_first  = tally[FIRST_SINGLES];
         counts.single_second = tally[SECOND_SINGLES];
         counts.coincidences  = tally[COINCIDENT];
         pending_counts.push_back(counts);
         clear_tally();
      end else begin
         other = w.channel ^ 1'b1;
         last_pulse_us[w.channel] = w.time_us;
         since_other = w.time_us - last_pulse_us[other];
         if (since_other < window_now) begin
            tally[COINCIDENT] = tally[COINCIDENT] + 1'b1;
            // the other side's earlier pulse becomes half of the pair
            tally[other] = tally[other] - 1'b1;
         end else begin
            tally[w.channel] = tally[w.channel] + 1'b1;
         end
      end
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) note_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
   endtask

   // result checker
   always @(posedge clock) begin : check_counts
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_counts.size() == 0) begin
            note_mismatch($sformatf("unexpected word %h", rsp_word));
         end else begin
            want = pending_counts.pop_front();
            check_field("single_first", want.single_first, rsp_word.single_first);
            check_field("single_second", want.single_second, rsp_word.single_second);
            check_field("coincidences", want.coincidences, rsp_word.coincidences);
         end
      end
   end

   // receiver stall pattern: alternating stretches of random length
   always @(posedge clock) begin
      if (!receiver_stalls) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left == 0) begin
         stall_phase = !stall_phase;
         stall_left = stall_phase ? $urandom_range(1, 12) : $urandom_range(1, 10);
         rsp_stall <= stall_phase;
      end else begin
         stall_left--;
      end
   end

   task automatic pause_sender(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // drive one word, wait for acceptance, predict, then maybe open a gap
   task automatic send_word(input req_word_type w);
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      count_word(w);
      if (sender_idles) begin
         if (burst_left == 0) begin
            pause_sender($urandom_range(1, 8));
            burst_left = $urandom_range(1, 16);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic pulse(input logic ch, input logic [TIME_IN_WIDTH-1:0] t);
      req_word_type w;
      w.req_type = REQ_PULSE;
      w.channel  = ch;
      w.time_us  = t;
      send_word(w);
   endtask

   task automatic read_counts();
      req_word_type w;
      w.req_type = REQ_READ;
      w.channel  = 1'($urandom_range(0, 1));
      w.time_us  = $urandom;
      send_word(w);
   endtask

   task automatic wait_drained();
      int unsigned guard;
      guard = 0;
      req_valid <= 1'b0;
      while (pending_counts.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [WINDOW_WIDTH-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      window_now = value;
   endtask

   // both last times start at zero, so early pulses pair with time zero
   task automatic test_after_reset();
      pulse(CH_FIRST, 32'd10);
      pulse(CH_SECOND, 32'd49);
      read_counts();
      read_counts();
   endtask

   task automatic test_directed_edges();
      // elapsed equal to the window is not a coincidence, one below is
      pulse(CH_FIRST, 32'd1000);
      pulse(CH_SECOND, 32'd1050);
      pulse(CH_FIRST, 32'd1099);
      // repeats on one channel stay singles
      pulse(CH_FIRST, 32'd5000);
      pulse(CH_FIRST, 32'd5001);
      read_counts();
      // elapsed time across the timestamp wrap
      pulse(CH_SECOND, 32'hFFFF_FFF0);
      pulse(CH_FIRST, 32'h0000_0010);
      pulse(CH_FIRST, 32'hFFFF_FFFF);
      pulse(CH_SECOND, 32'h0000_0000);
      read_counts();
      // single count wraps below zero and back up through zero
      pulse(CH_FIRST, 32'h1000_0000);
      read_counts();
      pulse(CH_SECOND, 32'h1000_0005);
      pulse(CH_FIRST, 32'h2000_0000);
      read_counts();
   endtask

   task automatic test_window_extremes();
      write_window(16'd0);
      pulse(CH_FIRST, 32'd7000);
      pulse(CH_SECOND, 32'd7000);
      read_counts();
      write_window(16'hFFFF);
      pulse(CH_FIRST, 32'd8000);
      pulse(CH_SECOND, 32'd8000 + 32'd65534);
      pulse(CH_FIRST, 32'd8000 + 32'd65534 + 32'd65535);
      read_counts();
      write_window(16'd1);
      pulse(CH_FIRST, 32'd9000);
      pulse(CH_SECOND, 32'd9000);
      read_counts();
   endtask

   task automatic test_random_traffic();
      logic [WINDOW_WIDTH-1:0] windows [6];
      logic                    ch;
      int unsigned             pick;
      int unsigned             spread;
      windows = '{16'd50, 16'hFFFF, 16'd0, 16'($urandom_range(1, 16)), 16'($urandom),
                  16'($urandom_range(100, 3000))};
      ch = CH_FIRST;
      for (int p = 0; p < 6; p++) begin
         write_window(windows[p]);
         // the first phase runs with no idling on either side
         sender_idles    = (p != 0);
         receiver_stalls = (p != 0) && ($urandom_range(0, 3) != 0);
         spread = int'(windows[p]) + int'(windows[p]) / 2 + 2;
         for (int i = 0; i < 170; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               read_counts();
            end else if (pick < 20) begin
               pulse(1'($urandom_range(0, 1)), $urandom);
            end else begin
               if (pick < 25) now_us = now_us + $urandom;
               else now_us = now_us + $urandom_range(0, spread);
               // mostly alternate channels so pairs form
               if ($urandom_range(0, 9) < 7) ch = !ch;
               pulse(ch, now_us);
            end
            if ($urandom_range(0, 99) < 2) wait_drained();
         end
         read_counts();
      end
      sender_idles    = 1'b0;
      receiver_stalls = 1'b0;
   endtask

   initial begin
      window_now = WINDOW_RESET;
      last_pulse_us[0] = '0;
      last_pulse_us[1] = '0;
      clear_tally();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_after_reset();
      test_directed_edges();
      test_window_extremes();
      test_random_traffic();
      wait_drained();
      if (pending_counts.size() != 0)
         note_mismatch($sformatf("%0d words never arrived", pending_counts.size()));
      if (mismatches == 0) begin
         $display("PASS two_channel_coincidence_counter");
      end else begin
         $display("FAIL two_channel_coincidence_counter");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL two_channel_coincidence_counter");
      $finish;
   end

endmodule
